// ===== rtl/cgoe_pkg.sv =====
package cgoe_pkg;

	// fixed field widths of the block's ports
	localparam int FLEET_W   = 2;
	localparam int CELL_W    = 10;
	localparam int IDX_W     = 20;
	localparam int GEO_W     = 24;
	localparam int CFG_IDX_W = 4;

	// cell size 1..4 after saturation
	localparam int CS_W      = 4;
	// compare width for grid dimensions up to 4096
	localparam int DIM_CMP_W = 13;

	// geometry register layout
	localparam int GEO_CS_LO = 0;
	localparam int GEO_W_LO  = 2;
	localparam int GEO_H_LO  = 13;
	localparam int GEO_DIM_W = 11;

	typedef struct packed {
		logic load;   // capture the query
		logic box;    // compute the query cell's world box
		logic fsel;   // latch geometry of the current fleet
		logic fnext;  // advance to the next fleet
		logic div1;   // span division, reciprocal product
		logic div2;   // span division, correction and clip
		logic span;   // set up the row walk
		logic emit;   // produce one overlapping cell
		logic flush;  // release the held cell as the final one
	} ctl_cmd_t;

	typedef struct packed {
		logic qf_bad;      // query fleet out of range
		logic fleet_skip;  // current fleet is the query fleet or empty
		logic last_fleet;  // current fleet is the highest one
		logic span_empty;  // clipped span holds no cell
		logic fleet_done;  // current cell closes the fleet's span
		logic can_push;    // a new cell can be taken this cycle
		logic flush_ok;    // the held cell can be released this cycle
	} ctl_sts_t;

endpackage

// ===== rtl/cross_grid_overlap_enumerator.sv =====
// Sequence: after the accepting beat, a box step, then per fleet (query fleet included)
// a skip, or geometry select, span division (DIV1, DIV2) and row-walk setup followed by
// an emit per overlapping cell, then a flush; a held cell is registered out as the next
// is walked. One query at a time: in_stall stays high from acceptance until the flush,
// and a stalled output holds the walk; the last held cell goes out with the flush.
// Reset: arst_n clears the fleet geometry to zero (cell size 1, empty grids), empties the
// output register and returns the controller to idle, ready for a query.
module cross_grid_overlap_enumerator #(
	parameter int NUM_FLEETS    = 4,
	parameter int MAX_CELL_SIZE = 4,
	parameter int MAX_GRID_DIM  = 1024
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [cgoe_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [cgoe_pkg::GEO_W-1:0]     cfg_wdata,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [cgoe_pkg::FLEET_W-1:0]   query_fleet,
	input  logic [cgoe_pkg::CELL_W-1:0]    cell_x,
	input  logic [cgoe_pkg::CELL_W-1:0]    cell_y,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [cgoe_pkg::FLEET_W-1:0]   other_fleet,
	output logic [cgoe_pkg::IDX_W-1:0]     overlap_idx,
	output logic                           last
);

	cgoe_pkg::ctl_cmd_t cmd;
	cgoe_pkg::ctl_sts_t sts;

	// sequence control
	cgoe_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// geometry, span arithmetic and output beat
	cgoe_dp #(
		.NUM_FLEETS    (NUM_FLEETS),
		.MAX_CELL_SIZE (MAX_CELL_SIZE),
		.MAX_GRID_DIM  (MAX_GRID_DIM)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata),
		.query_fleet (query_fleet),
		.cell_x      (cell_x),
		.cell_y      (cell_y),
		.cmd         (cmd),
		.sts         (sts),
		.out_stall   (out_stall),
		.out_valid   (out_valid),
		.other_fleet (other_fleet),
		.overlap_idx (overlap_idx),
		.last        (last)
	);

endmodule

// ===== rtl/cgoe_ctrl.sv =====
module cgoe_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  cgoe_pkg::ctl_sts_t sts,
	output cgoe_pkg::ctl_cmd_t cmd
);

	typedef enum logic [2:0] {
		IDLE,
		BOX,
		FSEL,
		DIV1,
		DIV2,
		SPAN,
		EMIT,
		FLUSH
	} state_t;

	state_t state_q;
	logic   in_stall_q;

	assign in_stall = in_stall_q;

	// decode commands from state and status
	always_comb begin
		cmd = '0;
		unique case (state_q)
			IDLE:  cmd.load  = in_valid && !sts.qf_bad;
			BOX:   cmd.box   = 1'b1;
			FSEL: begin
				cmd.fsel  = !sts.fleet_skip;
				cmd.fnext = sts.fleet_skip && !sts.last_fleet;
			end
			DIV1:  cmd.div1  = 1'b1;
			DIV2:  cmd.div2  = 1'b1;
			SPAN: begin
				cmd.span  = !sts.span_empty;
				cmd.fnext = sts.span_empty && !sts.last_fleet;
			end
			EMIT: begin
				cmd.emit  = sts.can_push;
				cmd.fnext = sts.can_push && sts.fleet_done && !sts.last_fleet;
			end
			FLUSH: cmd.flush = sts.flush_ok;
			default: cmd = '0;
		endcase
	end

	// sequence the query through the fleets
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= IDLE;
			in_stall_q <= 1'b0;
		end else begin
			unique case (state_q)
				IDLE: begin
					if (in_valid && !sts.qf_bad) begin
						state_q    <= BOX;
						in_stall_q <= 1'b1;
					end
				end
				BOX:  state_q <= FSEL;
				FSEL: begin
					if (!sts.fleet_skip)
						state_q <= DIV1;
					else if (sts.last_fleet)
						state_q <= FLUSH;
				end
				DIV1: state_q <= DIV2;
				DIV2: state_q <= SPAN;
				SPAN: begin
					if (!sts.span_empty)
						state_q <= EMIT;
					else if (sts.last_fleet)
						state_q <= FLUSH;
					else
						state_q <= FSEL;
				end
				EMIT: begin
					if (sts.can_push && sts.fleet_done)
						state_q <= sts.last_fleet ? FLUSH : FSEL;
				end
				FLUSH: begin
					if (sts.flush_ok) begin
						state_q    <= IDLE;
						in_stall_q <= 1'b0;
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

endmodule

// ===== rtl/cgoe_dp.sv =====
module cgoe_dp #(
	parameter int NUM_FLEETS    = 4,
	parameter int MAX_CELL_SIZE = 4,
	parameter int MAX_GRID_DIM  = 1024
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [cgoe_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [cgoe_pkg::GEO_W-1:0]         cfg_wdata,
	input  logic [cgoe_pkg::FLEET_W-1:0]       query_fleet,
	input  logic [cgoe_pkg::CELL_W-1:0]        cell_x,
	input  logic [cgoe_pkg::CELL_W-1:0]        cell_y,
	input  cgoe_pkg::ctl_cmd_t                 cmd,
	output cgoe_pkg::ctl_sts_t                 sts,
	input  logic                               out_stall,
	output logic                               out_valid,
	output logic [cgoe_pkg::FLEET_W-1:0]       other_fleet,
	output logic [cgoe_pkg::IDX_W-1:0]         overlap_idx,
	output logic                               last
);

	localparam int FW    = $clog2(NUM_FLEETS);
	localparam int CSW   = cgoe_pkg::CS_W;
	localparam int CW    = cgoe_pkg::CELL_W + $clog2(MAX_CELL_SIZE + 1);
	localparam int DW    = CW + 1;
	localparam int DIMW  = $clog2(MAX_GRID_DIM + 1);
	localparam int SPW   = (DW > DIMW) ? DW : DIMW;
	localparam int RS    = DW;
	localparam int RW    = RS + 1;
	localparam int PW    = DW + RW;
	localparam int MW    = SPW + DIMW;
	localparam int IDXW  = cgoe_pkg::IDX_W;
	localparam int CMPW  = cgoe_pkg::DIM_CMP_W;
	localparam int XW    = cgoe_pkg::CFG_IDX_W;

	// reciprocals floor(2^RS / d) for the span divisions
	localparam logic [RW-1:0] R1 = RW'((1 << RS) / 1);
	localparam logic [RW-1:0] R2 = RW'((1 << RS) / 2);
	localparam logic [RW-1:0] R3 = RW'((1 << RS) / 3);
	localparam logic [RW-1:0] R4 = RW'((1 << RS) / 4);
	localparam logic [RW-1:0] R5 = RW'((1 << RS) / 5);
	localparam logic [RW-1:0] R6 = RW'((1 << RS) / 6);
	localparam logic [RW-1:0] R7 = RW'((1 << RS) / 7);
	localparam logic [RW-1:0] R8 = RW'((1 << RS) / 8);

	function automatic logic [RW-1:0] recip(input logic [CSW-1:0] d);
		unique case (d)
			CSW'(2): return R2;
			CSW'(3): return R3;
			CSW'(4): return R4;
			CSW'(5): return R5;
			CSW'(6): return R6;
			CSW'(7): return R7;
			CSW'(8): return R8;
			default: return R1;
		endcase
	endfunction

	function automatic logic [CSW-1:0] cs_of(input logic [1:0] f);
		logic [CSW-1:0] c;
		c = CSW'(f) + CSW'(1);
		return (c > CSW'(MAX_CELL_SIZE)) ? CSW'(MAX_CELL_SIZE) : c;
	endfunction

	function automatic logic [DIMW-1:0] dim_clip(input logic [cgoe_pkg::GEO_DIM_W-1:0] raw);
		if (CMPW'(raw) > CMPW'(MAX_GRID_DIM))
			return DIMW'(MAX_GRID_DIM);
		else
			return DIMW'(raw);
	endfunction

	// geometry registers and read pointer
	logic [cgoe_pkg::GEO_W-1:0]   geom_q [NUM_FLEETS];
	logic [cgoe_pkg::GEO_W-1:0]   g_rd;
	logic [FW-1:0]                f_q;
	logic [cgoe_pkg::FLEET_W-1:0] qf_q;
	logic [cgoe_pkg::CELL_W-1:0]  x_q;
	logic [cgoe_pkg::CELL_W-1:0]  y_q;

	// query box and current fleet geometry
	logic [CW-1:0]   x0_q, y0_q, x1_q, y1_q;
	logic [CSW-1:0]  bcs;
	logic [CW-1:0]   bx0, by0;
	logic [CSW-1:0]  ocs_q;
	logic [DIMW-1:0] w_q, h_q;

	// span division lanes: start x, start y, end x, end y
	logic [DW-1:0]  num   [4];
	logic [PW-1:0]  prod  [4];
	logic [DW-1:0]  n_s1  [4];
	logic [DW-1:0]  qe_s1 [4];
	logic [DW-1:0]  rem   [4];
	logic [DW-1:0]  quo   [4];

	// row walk
	logic [SPW-1:0]  sx_q, sy_q, ex_q, ey_q;
	logic [SPW-1:0]  ox_q, oy_q;
	logic [IDXW-1:0] row_base_q;
	logic [MW-1:0]   row_prod;
	logic            row_end;
	logic [IDXW-1:0] new_idx;

	// held cell and output register
	logic                         pend_valid_q;
	logic [cgoe_pkg::FLEET_W-1:0] pend_fleet_q;
	logic [IDXW-1:0]              pend_idx_q;
	logic                         out_valid_q;
	logic [cgoe_pkg::FLEET_W-1:0] other_fleet_q;
	logic [IDXW-1:0]              overlap_idx_q;
	logic                         last_q;
	logic                         out_free;
	logic                         push_en;
	logic                         push_last;
	logic [XW-1:0]                qf_ext;
	logic [XW-1:0]                f_ext;

	assign qf_ext = XW'(query_fleet);
	assign f_ext  = XW'(f_q);
	assign g_rd   = geom_q[f_q];

	// take configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_FLEETS; i++)
				geom_q[i] <= '0;
		end else begin
			for (int i = 0; i < NUM_FLEETS; i++)
				if (cfg_we && cfg_index == XW'(i))
					geom_q[i] <= cfg_wdata;
		end
	end

	// world box of the query cell
	assign bcs = cs_of(g_rd[cgoe_pkg::GEO_CS_LO +: 2]);
	assign bx0 = CW'(x_q) * CW'(bcs);
	assign by0 = CW'(y_q) * CW'(bcs);

	// reciprocal product per lane
	assign num[0] = DW'(x0_q);
	assign num[1] = DW'(y0_q);
	assign num[2] = DW'(x1_q) + DW'(ocs_q) - DW'(1);
	assign num[3] = DW'(y1_q) + DW'(ocs_q) - DW'(1);

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			prod[i] = PW'(num[i]) * PW'(recip(ocs_q));
			rem[i]  = n_s1[i] - DW'(qe_s1[i]) * DW'(ocs_q);
			quo[i]  = (rem[i] >= DW'(ocs_q)) ? qe_s1[i] + DW'(1) : qe_s1[i];
		end
	end

	assign row_prod = MW'(sy_q) * MW'(w_q);
	assign row_end  = (ox_q + SPW'(1)) == ex_q;
	assign new_idx  = row_base_q + IDXW'(ox_q);

	// query, box, fleet and span registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			qf_q <= query_fleet;
			x_q  <= cell_x;
			y_q  <= cell_y;
			f_q  <= qf_ext[FW-1:0];
		end
		if (cmd.box) begin
			x0_q <= bx0;
			y0_q <= by0;
			x1_q <= bx0 + CW'(bcs);
			y1_q <= by0 + CW'(bcs);
			f_q  <= '0;
		end
		if (cmd.fnext)
			f_q <= f_q + FW'(1);
		if (cmd.fsel) begin
			ocs_q <= cs_of(g_rd[cgoe_pkg::GEO_CS_LO +: 2]);
			w_q   <= dim_clip(g_rd[cgoe_pkg::GEO_W_LO +: cgoe_pkg::GEO_DIM_W]);
			h_q   <= dim_clip(g_rd[cgoe_pkg::GEO_H_LO +: cgoe_pkg::GEO_DIM_W]);
		end
		if (cmd.div1) begin
			for (int i = 0; i < 4; i++) begin
				n_s1[i]  <= num[i];
				qe_s1[i] <= prod[i][RS +: DW];
			end
		end
		if (cmd.div2) begin
			sx_q <= SPW'(quo[0]);
			sy_q <= SPW'(quo[1]);
			ex_q <= (SPW'(quo[2]) > SPW'(w_q)) ? SPW'(w_q) : SPW'(quo[2]);
			ey_q <= (SPW'(quo[3]) > SPW'(h_q)) ? SPW'(h_q) : SPW'(quo[3]);
		end
		if (cmd.span) begin
			row_base_q <= IDXW'(row_prod);
			ox_q       <= sx_q;
			oy_q       <= sy_q;
		end
		if (cmd.emit) begin
			if (row_end) begin
				ox_q       <= sx_q;
				oy_q       <= oy_q + SPW'(1);
				row_base_q <= row_base_q + IDXW'(w_q);
			end else begin
				ox_q <= ox_q + SPW'(1);
			end
		end
	end

	// hold one cell back so the final one can be flagged
	assign out_free  = !out_valid_q || !out_stall;
	assign push_en   = (cmd.emit && pend_valid_q) || (cmd.flush && pend_valid_q);
	assign push_last = cmd.flush;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cmd.emit)
				pend_valid_q <= 1'b1;
			else if (cmd.flush)
				pend_valid_q <= 1'b0;
			if (out_free)
				out_valid_q <= push_en;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			pend_fleet_q <= f_ext[cgoe_pkg::FLEET_W-1:0];
			pend_idx_q   <= new_idx;
		end
		if (push_en && out_free) begin
			other_fleet_q <= pend_fleet_q;
			overlap_idx_q <= pend_idx_q;
			last_q        <= push_last;
		end
	end

	assign out_valid   = out_valid_q;
	assign other_fleet = other_fleet_q;
	assign overlap_idx = overlap_idx_q;
	assign last        = last_q;

	// status toward the controller
	assign sts.qf_bad     = qf_ext >= XW'(NUM_FLEETS);
	assign sts.fleet_skip = (f_ext == XW'(qf_q))
		|| (g_rd[cgoe_pkg::GEO_W_LO +: cgoe_pkg::GEO_DIM_W] == '0)
		|| (g_rd[cgoe_pkg::GEO_H_LO +: cgoe_pkg::GEO_DIM_W] == '0);
	assign sts.last_fleet = f_q == FW'(NUM_FLEETS - 1);
	assign sts.span_empty = (sx_q >= ex_q) || (sy_q >= ey_q);
	assign sts.fleet_done = row_end && ((oy_q + SPW'(1)) == ey_q);
	assign sts.can_push   = !pend_valid_q || out_free;
	assign sts.flush_ok   = !pend_valid_q || out_free;

	// a waiting result is never overwritten
	a_push_free: assert property (@(posedge clk) disable iff (!arst_n)
		push_en |-> out_free)
		else $error("result pushed into a stalled output register");

	// a walked cell lies inside the clipped span
	a_emit_span: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (ox_q < ex_q) && (oy_q < ey_q) && (ox_q >= sx_q))
		else $error("emitted cell outside its span");

	// the held cell is gone once the query is flushed
	a_flush_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.flush |=> !pend_valid_q)
		else $error("held cell survived the flush");

	// the final flag only comes from a flush
	a_last_flush: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !$stable(overlap_idx_q) && last_q) |-> $past(cmd.flush))
		else $error("final flag raised outside a flush");

endmodule

// ===== tb/tb_top.sv =====
module tb_top;

	localparam int FLEET_W   = cgoe_pkg::FLEET_W;
	localparam int CELL_W    = cgoe_pkg::CELL_W;
	localparam int IDX_W     = cgoe_pkg::IDX_W;
	localparam int GEO_W     = cgoe_pkg::GEO_W;
	localparam int CFG_IDX_W = cgoe_pkg::CFG_IDX_W;
	localparam int GEO_CS_LO = cgoe_pkg::GEO_CS_LO;
	localparam int GEO_W_LO  = cgoe_pkg::GEO_W_LO;
	localparam int GEO_H_LO  = cgoe_pkg::GEO_H_LO;
	localparam int GEO_DIM_W = cgoe_pkg::GEO_DIM_W;

	localparam int NUM_FLEETS    = 4;
	localparam int MAX_CELL_SIZE = 4;
	localparam int MAX_GRID_DIM  = 1024;

	// geometry register map: one register per fleet, starting at index zero
	localparam logic [CFG_IDX_W-1:0] GEO_REG_FLEET0 = 4'd0;
	localparam logic [CFG_IDX_W-1:0] GEO_REG_FLEET1 = 4'd1;
	localparam logic [CFG_IDX_W-1:0] GEO_REG_FLEET2 = 4'd2;
	localparam logic [CFG_IDX_W-1:0] GEO_REG_FLEET3 = 4'd3;
	// indexes past the last fleet, which the block must drop
	localparam logic [CFG_IDX_W-1:0] GEO_REG_UNMAPPED_LO = 4'd4;
	localparam logic [CFG_IDX_W-1:0] GEO_REG_UNMAPPED_HI = 4'd15;

	// idle cycles after the last expected beat before reconfiguring or ending
	localparam int SETTLE_CYCLES = 64;

	typedef struct {
		logic [FLEET_W-1:0] fleet;
		logic [CELL_W-1:0]  x;
		logic [CELL_W-1:0]  y;
		bit                 drain_first;
	} query_t;

	typedef struct {
		logic [FLEET_W-1:0] fleet;
		logic [IDX_W-1:0]   index;
		logic               last;
	} overlap_t;

	logic                 clk          = 1'b0;
	logic                 arst_n       = 1'b0;
	logic                 cfg_we       = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index    = '0;
	logic [GEO_W-1:0]     cfg_wdata    = '0;
	logic                 in_valid     = 1'b0;
	logic                 in_stall;
	logic [FLEET_W-1:0]   query_fleet  = '0;
	logic [CELL_W-1:0]    cell_x       = '0;
	logic [CELL_W-1:0]    cell_y       = '0;
	logic                 out_valid;
	logic                 out_stall    = 1'b0;
	logic [FLEET_W-1:0]   other_fleet;
	logic [IDX_W-1:0]     overlap_idx;
	logic                 last;

	query_t           query_q[$];
	overlap_t         overlap_q[$];
	logic [GEO_W-1:0] fleet_geo[NUM_FLEETS];
	int               send_idle_pct = 0;
	int               recv_idle_pct = 0;
	int               mismatch_count = 0;

	cross_grid_overlap_enumerator #(
		.NUM_FLEETS   (NUM_FLEETS),
		.MAX_CELL_SIZE(MAX_CELL_SIZE),
		.MAX_GRID_DIM (MAX_GRID_DIM)
	) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.query_fleet(query_fleet),
		.cell_x     (cell_x),
		.cell_y     (cell_y),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.other_fleet(other_fleet),
		.overlap_idx(overlap_idx),
		.last       (last)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("[cross_grid_overlap_enumerator] ERROR");
		$finish;
	end

	task automatic flag_mismatch(input string msg);
		$display("mismatch at %0t: %s", $time, msg);
		mismatch_count++;
	endtask

	// saturated cell size of a geometry word
	function automatic int geo_cell_size(input logic [GEO_W-1:0] g);
		int c;
		c = int'(g[GEO_W_LO-1:GEO_CS_LO]) + 1;
		return (c > MAX_CELL_SIZE) ? MAX_CELL_SIZE : c;
	endfunction

	// saturated grid dimension
	function automatic int grid_dim(input logic [GEO_DIM_W-1:0] d);
		return (int'(d) > MAX_GRID_DIM) ? MAX_GRID_DIM : int'(d);
	endfunction

	function automatic logic [GEO_W-1:0] pack_geometry(input int cs_code, input int w, input int h);
		logic [GEO_W-1:0] g;
		g = '0;
		g[GEO_W_LO-1:GEO_CS_LO] = 2'(cs_code);
		g[GEO_H_LO-1:GEO_W_LO]  = GEO_DIM_W'(w);
		g[GEO_W-1:GEO_H_LO]     = GEO_DIM_W'(h);
		return g;
	endfunction

	// enumerate the cells of every other fleet that the query cell's box touches
	function automatic void predict_overlaps(input logic [FLEET_W-1:0] qf,
			input logic [CELL_W-1:0] x, input logic [CELL_W-1:0] y);
		int       first, cs, x0, y0, x1, y1, ocs, w, h, sx, sy, ex, ey;
		overlap_t o;
		first = overlap_q.size();
		cs = geo_cell_size(fleet_geo[qf]);
		x0 = int'(x) * cs;
		y0 = int'(y) * cs;
		x1 = x0 + cs;
		y1 = y0 + cs;
		for (int f = 0; f < NUM_FLEETS; f++) begin
			w = grid_dim(fleet_geo[f][GEO_H_LO-1:GEO_W_LO]);
			h = grid_dim(fleet_geo[f][GEO_W-1:GEO_H_LO]);
			if (f == int'(qf) || w == 0 || h == 0)
				continue;
			ocs = geo_cell_size(fleet_geo[f]);
			sx = x0 / ocs;
			sy = y0 / ocs;
			ex = (x1 + ocs - 1) / ocs;
			ey = (y1 + ocs - 1) / ocs;
			if (ex > w)
				ex = w;
			if (ey > h)
				ey = h;
			for (int oy = sy; oy < ey; oy++) begin
				for (int ox = sx; ox < ex; ox++) begin
					o.fleet = FLEET_W'(f);
					o.index = IDX_W'(w * oy + ox);
					o.last  = 1'b0;
					overlap_q = {overlap_q, o};
				end
			end
		end
		// flag the final cell of this query
		if (overlap_q.size() > first)
			overlap_q[overlap_q.size() - 1].last = 1'b1;
	endfunction

	function automatic int random_dim();
		int r;
		r = $urandom_range(99);
		if (r < 10)
			return 0;
		if (r < 90)
			return $urandom_range(24, 1);
		return $urandom_range(2047);
	endfunction

	function automatic logic [GEO_W-1:0] random_geometry();
		return pack_geometry($urandom_range(3), random_dim(), random_dim());
	endfunction

	// mostly cells inside the query fleet's own grid, some anywhere
	function automatic query_t random_query();
		query_t q;
		int     w, h;
		q.fleet = FLEET_W'($urandom_range(NUM_FLEETS - 1));
		w = grid_dim(fleet_geo[q.fleet][GEO_H_LO-1:GEO_W_LO]);
		h = grid_dim(fleet_geo[q.fleet][GEO_W-1:GEO_H_LO]);
		if (w != 0 && h != 0 && $urandom_range(99) < 85) begin
			q.x = CELL_W'($urandom_range(w - 1));
			q.y = CELL_W'($urandom_range(h - 1));
		end else begin
			q.x = CELL_W'($urandom_range(1023));
			q.y = CELL_W'($urandom_range(1023));
		end
		q.drain_first = ($urandom_range(99) < 3);
		return q;
	endfunction

	task automatic add_query(input int f, input int x, input int y, input bit drain_first);
		query_t q;
		q.fleet       = FLEET_W'(f);
		q.x           = CELL_W'(x);
		q.y           = CELL_W'(y);
		q.drain_first = drain_first;
		query_q = {query_q, q};
	endtask

	task automatic add_random_queries(input int n);
		for (int i = 0; i < n; i++)
			query_q = {query_q, random_query()};
	endtask

	// one write per clock; the block ignores indexes past the last fleet
	task automatic write_geometry(input logic [CFG_IDX_W-1:0] idx, input logic [GEO_W-1:0] value);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		if (int'(idx) < NUM_FLEETS)
			fleet_geo[idx] = value;
	endtask

	task automatic end_writes();
		@(posedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic write_random_geometry();
		for (int i = 0; i < NUM_FLEETS; i++)
			write_geometry(GEO_REG_FLEET0 + CFG_IDX_W'(i), random_geometry());
		end_writes();
	endtask

	// wait until every query is taken and every cell has come back
	task automatic settle();
		do
			@(negedge clk);
		while (query_q.size() != 0 || in_valid || overlap_q.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// query driver: hold a stalled beat, otherwise present the next pending query
	always @(posedge clk) begin : query_driver
		bit accepted;
		bit present;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			accepted = in_valid && !in_stall;
			if (accepted) begin
				predict_overlaps(query_fleet, cell_x, cell_y);
				void'(query_q.pop_front());
			end
			if (in_valid && !accepted) begin
				present = 1'b1;
			end else begin
				present = query_q.size() != 0
					&& (!query_q[0].drain_first || overlap_q.size() == 0)
					&& $urandom_range(99) >= send_idle_pct;
				if (present) begin
					query_fleet <= query_q[0].fleet;
					cell_x      <= query_q[0].x;
					cell_y      <= query_q[0].y;
				end
			end
			in_valid <= present;
		end
	end

	// result monitor: compare each accepted beat with the oldest expected cell
	always @(posedge clk) begin : result_monitor
		overlap_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (overlap_q.size() == 0) begin
					flag_mismatch($sformatf("unexpected cell fleet %0d index %0d last %0b",
						other_fleet, overlap_idx, last));
				end else begin
					want = overlap_q.pop_front();
					if (other_fleet !== want.fleet)
						flag_mismatch($sformatf("other_fleet got %0d want %0d",
							other_fleet, want.fleet));
					if (overlap_idx !== want.index)
						flag_mismatch($sformatf("overlap_idx got %0d want %0d (fleet %0d)",
							overlap_idx, want.index, want.fleet));
					if (last !== want.last)
						flag_mismatch($sformatf("last got %0b want %0b (fleet %0d index %0d)",
							last, want.last, want.fleet, want.index));
				end
			end
			out_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	initial begin : stimulus
		for (int i = 0; i < NUM_FLEETS; i++)
			fleet_geo[i] = '0;
		send_idle_pct = 38;
		recv_idle_pct = 62;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// all grids empty after reset: no cells at all
		add_query(0, 0, 0, 1'b0);
		add_query(3, 1023, 1023, 1'b0);
		settle();

		// mixed sizes, fleet 2 has zero width; junk to unmapped indexes
		write_geometry(GEO_REG_FLEET0, pack_geometry(0, 16, 16));
		write_geometry(GEO_REG_FLEET1, pack_geometry(3, 12, 12));
		write_geometry(GEO_REG_FLEET2, pack_geometry(1, 0, 10));
		write_geometry(GEO_REG_FLEET3, pack_geometry(2, 20, 20));
		write_geometry(GEO_REG_UNMAPPED_LO, 24'hFFFFFF);
		write_geometry(GEO_REG_UNMAPPED_HI, 24'hFFFFFF);
		end_writes();
		add_query(0, 0, 0, 1'b0);
		add_query(1, 0, 0, 1'b0);
		add_query(1, 11, 11, 1'b0);
		add_query(3, 19, 19, 1'b0);
		add_query(2, 3, 3, 1'b0);
		add_query(0, 500, 500, 1'b0);
		add_query(0, 15, 15, 1'b0);
		add_query(3, 5, 5, 1'b1);
		add_random_queries(80);
		settle();

		// swap idling; saturating sizes and the largest grids
		send_idle_pct = 62;
		recv_idle_pct = 38;
		write_geometry(GEO_REG_FLEET0, 24'hFFFFFF);
		write_geometry(GEO_REG_FLEET1, pack_geometry(0, 1, 1));
		write_geometry(GEO_REG_FLEET2, pack_geometry(0, 1024, 1024));
		write_geometry(GEO_REG_FLEET3, pack_geometry(3, 2047, 0));
		end_writes();
		add_query(1, 1023, 1023, 1'b0);
		add_query(2, 1023, 1023, 1'b0);
		add_query(0, 1023, 1023, 1'b0);
		add_query(3, 0, 0, 1'b0);
		add_query(0, 255, 255, 1'b1);
		add_query(2, 0, 1023, 1'b0);
		add_random_queries(40);
		settle();
		write_random_geometry();
		add_random_queries(40);
		settle();

		// no idling; first the densest case, coarse query over three fine grids
		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_geometry(GEO_REG_FLEET0, pack_geometry(3, 8, 8));
		write_geometry(GEO_REG_FLEET1, pack_geometry(0, 32, 32));
		write_geometry(GEO_REG_FLEET2, pack_geometry(0, 32, 32));
		write_geometry(GEO_REG_FLEET3, pack_geometry(0, 32, 32));
		end_writes();
		add_query(0, 7, 7, 1'b0);
		add_query(0, 0, 0, 1'b0);
		settle();
		for (int k = 0; k < 3; k++) begin
			write_random_geometry();
			add_random_queries(30);
			settle();
		end

		if (overlap_q.size() != 0)
			flag_mismatch($sformatf("%0d expected cells never came", overlap_q.size()));
		if (mismatch_count == 0)
			$display("[cross_grid_overlap_enumerator] OK");
		else
			$display("[cross_grid_overlap_enumerator] ERROR");
		$finish;
	end

endmodule
